// ----- rtl/gff_pkg.sv -----
`default_nettype none
package gff_pkg;

    localparam int ROWS   = 32;
    localparam int COLS   = 128;
    localparam int NCELLS = ROWS * COLS;

    localparam int ROW_W   = 5;
    localparam int COL_W   = 7;
    localparam int CHAR_W  = 8;
    localparam int CELL_W  = ROW_W + COL_W;
    localparam int ADDR_W  = $clog2(NCELLS);
    localparam int LEVEL_W = $clog2(NCELLS + 1);
    localparam int COUNT_W = 13;
    localparam int DIR_W   = 3;

    localparam int S_DATA_W = 24;
    localparam int S_USER_W = 2;
    localparam int M_DATA_W = 16;

    localparam logic [COUNT_W-1:0] COUNT_MAX = '1;
    localparam logic [DIR_W-1:0]   DIR_LAST  = '1;

    localparam logic [CHAR_W-1:0] CH_DOT  = 8'h2E;
    localparam logic [CHAR_W-1:0] CH_HASH = 8'h23;
    localparam logic [CHAR_W-1:0] CH_PLUS = 8'h2B;

    typedef enum logic [1:0] {
        REQ_WRITE = 2'd0,
        REQ_FLOOD = 2'd1,
        REQ_QUERY = 2'd2
    } req_t;

    // Step of a neighbor coordinate relative to the current cell.
    typedef enum logic [1:0] {
        OFF_NEG,
        OFF_ZERO,
        OFF_POS
    } off_t;

    typedef enum logic [3:0] {
        S_INIT,
        S_IDLE,
        S_QRD,
        S_FCHK,
        S_FCLR,
        S_FSEED,
        S_POP,
        S_LOAD,
        S_NRD,
        S_NCHK,
        S_RESULT
    } state_t;

    typedef struct packed {
        logic accept;
        logic in_write;
        logic in_take;
        logic clr_step;
        logic clr_walk;
        logic chk_start;
        logic seed;
        logic pop;
        logic load_cur;
        logic nbr_issue;
        logic nbr_check;
        logic dir_inc;
        logic res_zero;
        logic res_query;
        logic res_flood;
        logic out_load;
    } cmd_t;

    typedef struct packed {
        logic clr_done;
        logic level_zero;
        logic nbr_ok;
        logic dir_last;
        logic out_free;
        logic start_ok;
    } stat_t;

    function automatic logic [ADDR_W-1:0] cell_addr(input logic [ROW_W-1:0] r,
                                                    input logic [COL_W-1:0] c);
        cell_addr = ADDR_W'(32'(r) * COLS + 32'(c));
    endfunction

    function automatic logic is_walk(input logic [CHAR_W-1:0] ch);
        is_walk = (ch == CH_DOT) || (ch == CH_HASH) || (ch == CH_PLUS);
    endfunction

endpackage
`default_nettype wire

// ----- rtl/grid_flood_fill_8conn_core.sv -----
`default_nettype none
// Channel   Dir  Signals                               Contents
// s_axis    in   s_tvalid s_tready s_tdata s_tuser     request word, req_type in s_tuser
// m_axis    out  m_tvalid m_tready m_tdata             one result word per request
//
// A tile write or an unknown request goes from accept straight to the result; a query reads the visited map first.
// A flood checks the start cell and clears the whole visited map before its walk and result;
// each reached cell is popped from the stack, then every neighbor is tested, on-grid ones also checked.
// After reset, a sweep clears both maps; s_tready stays low meanwhile.
// One request is in work at a time, so the next request is taken only once a result is loaded;
// a result waiting in the output register only holds back the loading of the next result.
module grid_flood_fill_8conn_core (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              s_tvalid,
    output logic                                   s_tready,
    // [4:0] row, [11:5] col, [19:12] tile_char, [23:20] zero
    input  wire logic [gff_pkg::S_DATA_W-1:0]      s_tdata,
    // [1:0] req_type
    input  wire logic [gff_pkg::S_USER_W-1:0]      s_tuser,
    output logic                                   m_tvalid,
    input  wire logic                              m_tready,
    // [0] start_walkable, [13:1] cell_count, [14] visited_mark, [15] zero
    output logic      [gff_pkg::M_DATA_W-1:0]      m_tdata
);

    gff_pkg::cmd_t  cmd;
    gff_pkg::stat_t stat;

    gff_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .req      (s_tuser),
        .stat     (stat),
        .cmd      (cmd)
    );

    gff_dp u_dp (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tdata  (s_tdata),
        .cmd      (cmd),
        .stat     (stat),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

endmodule
`default_nettype wire

// ----- rtl/gff_ram.sv -----
`default_nettype none
module gff_ram #(
    parameter int WIDTH = 1,
    parameter int DEPTH = 4096
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule
`default_nettype wire

// ----- rtl/gff_ctrl.sv -----
`default_nettype none
module gff_ctrl (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              s_tvalid,
    output logic                                   s_tready,
    input  wire logic [gff_pkg::S_USER_W-1:0]      req,
    input  wire gff_pkg::stat_t                    stat,
    output gff_pkg::cmd_t                          cmd
);

    gff_pkg::state_t state_reg;
    gff_pkg::state_t state_next;
    logic            accept;

    assign s_tready = (state_reg == gff_pkg::S_IDLE);
    assign accept   = s_tvalid && s_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= gff_pkg::S_INIT;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            gff_pkg::S_INIT:
            begin
                if (stat.clr_done)
                begin
                    state_next = gff_pkg::S_IDLE;
                end
            end
            gff_pkg::S_IDLE:
            begin
                if (accept)
                begin
                    case (gff_pkg::req_t'(req))
                        gff_pkg::REQ_QUERY: state_next = gff_pkg::S_QRD;
                        gff_pkg::REQ_FLOOD: state_next = gff_pkg::S_FCHK;
                        default:            state_next = gff_pkg::S_RESULT;
                    endcase
                end
            end
            gff_pkg::S_QRD:  state_next = gff_pkg::S_RESULT;
            gff_pkg::S_FCHK: state_next = gff_pkg::S_FCLR;
            gff_pkg::S_FCLR:
            begin
                if (stat.clr_done)
                begin
                    state_next = stat.start_ok ? gff_pkg::S_FSEED : gff_pkg::S_RESULT;
                end
            end
            gff_pkg::S_FSEED: state_next = gff_pkg::S_POP;
            gff_pkg::S_POP:
            begin
                state_next = stat.level_zero ? gff_pkg::S_RESULT : gff_pkg::S_LOAD;
            end
            gff_pkg::S_LOAD: state_next = gff_pkg::S_NRD;
            gff_pkg::S_NRD:
            begin
                if (stat.nbr_ok)
                begin
                    state_next = gff_pkg::S_NCHK;
                end
                else if (stat.dir_last)
                begin
                    state_next = gff_pkg::S_POP;
                end
            end
            gff_pkg::S_NCHK:
            begin
                state_next = stat.dir_last ? gff_pkg::S_POP : gff_pkg::S_NRD;
            end
            gff_pkg::S_RESULT:
            begin
                if (stat.out_free)
                begin
                    state_next = gff_pkg::S_IDLE;
                end
            end
            default: state_next = gff_pkg::S_INIT;
        endcase
    end

    always_comb
    begin
        cmd = '0;
        case (state_reg)
            gff_pkg::S_INIT:
            begin
                cmd.clr_step = 1'b1;
                cmd.clr_walk = 1'b1;
            end
            gff_pkg::S_IDLE:
            begin
                if (accept)
                begin
                    cmd.accept = 1'b1;
                    case (gff_pkg::req_t'(req))
                        gff_pkg::REQ_WRITE:
                        begin
                            cmd.in_write = 1'b1;
                            cmd.res_zero = 1'b1;
                        end
                        gff_pkg::REQ_FLOOD: cmd.in_take = 1'b1;
                        gff_pkg::REQ_QUERY: ;
                        default:            cmd.res_zero = 1'b1;
                    endcase
                end
            end
            gff_pkg::S_QRD:  cmd.res_query = 1'b1;
            gff_pkg::S_FCHK: cmd.chk_start = 1'b1;
            gff_pkg::S_FCLR:
            begin
                cmd.clr_step = 1'b1;
                cmd.res_zero = stat.clr_done && !stat.start_ok;
            end
            gff_pkg::S_FSEED: cmd.seed = 1'b1;
            gff_pkg::S_POP:
            begin
                cmd.res_flood = stat.level_zero;
                cmd.pop       = !stat.level_zero;
            end
            gff_pkg::S_LOAD: cmd.load_cur = 1'b1;
            gff_pkg::S_NRD:
            begin
                cmd.nbr_issue = stat.nbr_ok;
                cmd.dir_inc   = !stat.nbr_ok;
            end
            gff_pkg::S_NCHK:
            begin
                cmd.nbr_check = 1'b1;
                cmd.dir_inc   = 1'b1;
            end
            gff_pkg::S_RESULT: cmd.out_load = stat.out_free;
            default: cmd = '0;
        endcase
    end

endmodule
`default_nettype wire

// ----- rtl/gff_dp.sv -----
`default_nettype none
module gff_dp (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic [gff_pkg::S_DATA_W-1:0]  s_tdata,
    input  wire gff_pkg::cmd_t                 cmd,
    output gff_pkg::stat_t                     stat,
    output logic                               m_tvalid,
    input  wire logic                          m_tready,
    output logic      [gff_pkg::M_DATA_W-1:0]  m_tdata
);

    localparam int AW = gff_pkg::ADDR_W;
    localparam int RW = gff_pkg::ROW_W;
    localparam int CW = gff_pkg::COL_W;

    logic [RW-1:0]                  in_row;
    logic [CW-1:0]                  in_col;
    logic [gff_pkg::CHAR_W-1:0]     in_char;
    logic                           in_inside;
    logic [AW-1:0]                  in_addr;

    logic [AW-1:0]                  clr_cnt_reg;
    logic                           inside_reg;
    logic                           start_ok_reg;
    logic [RW-1:0]                  cur_r_reg;
    logic [CW-1:0]                  cur_c_reg;
    logic [gff_pkg::DIR_W-1:0]      dir_reg;
    logic [RW-1:0]                  nbr_r_reg;
    logic [CW-1:0]                  nbr_c_reg;
    logic [gff_pkg::LEVEL_W-1:0]    level_reg;
    logic [gff_pkg::LEVEL_W-1:0]    level_dec;
    logic [gff_pkg::COUNT_W-1:0]    count_reg;
    logic                           res_sw_reg;
    logic [gff_pkg::COUNT_W-1:0]    res_cnt_reg;
    logic                           res_vm_reg;
    logic                           m_valid_reg;
    logic                           m_sw_reg;
    logic [gff_pkg::COUNT_W-1:0]    m_cnt_reg;
    logic                           m_vm_reg;

    gff_pkg::off_t                  dr;
    gff_pkg::off_t                  dc;
    logic [RW-1:0]                  nr;
    logic [CW-1:0]                  nc;
    logic                           ok_r;
    logic                           ok_c;
    logic [AW-1:0]                  nbr_addr;
    logic [AW-1:0]                  cur_addr;
    logic                           mark;
    logic                           push_room;

    logic                           walk_we;
    logic [AW-1:0]                  walk_waddr;
    logic                           walk_wdata;
    logic [AW-1:0]                  walk_raddr;
    logic                           walk_rdata;
    logic                           vis_we;
    logic [AW-1:0]                  vis_waddr;
    logic                           vis_wdata;
    logic [AW-1:0]                  vis_raddr;
    logic                           vis_rdata;
    logic                           stk_we;
    logic [AW-1:0]                  stk_waddr;
    logic [gff_pkg::CELL_W-1:0]     stk_wdata;
    logic [AW-1:0]                  stk_raddr;
    logic [gff_pkg::CELL_W-1:0]     stk_rdata;

    assign in_row  = s_tdata[RW-1:0];
    assign in_col  = s_tdata[gff_pkg::CELL_W-1:RW];
    assign in_char = s_tdata[gff_pkg::CELL_W+gff_pkg::CHAR_W-1:gff_pkg::CELL_W];
    assign in_inside = (32'(in_row) < gff_pkg::ROWS) && (32'(in_col) < gff_pkg::COLS);
    assign in_addr   = gff_pkg::cell_addr(in_row, in_col);

    // Eight neighbor directions, the center cell left out.
    always_comb
    begin
        case (dir_reg)
            3'd0:    begin dr = gff_pkg::OFF_NEG;  dc = gff_pkg::OFF_NEG;  end
            3'd1:    begin dr = gff_pkg::OFF_NEG;  dc = gff_pkg::OFF_ZERO; end
            3'd2:    begin dr = gff_pkg::OFF_NEG;  dc = gff_pkg::OFF_POS;  end
            3'd3:    begin dr = gff_pkg::OFF_ZERO; dc = gff_pkg::OFF_NEG;  end
            3'd4:    begin dr = gff_pkg::OFF_ZERO; dc = gff_pkg::OFF_POS;  end
            3'd5:    begin dr = gff_pkg::OFF_POS;  dc = gff_pkg::OFF_NEG;  end
            3'd6:    begin dr = gff_pkg::OFF_POS;  dc = gff_pkg::OFF_ZERO; end
            3'd7:    begin dr = gff_pkg::OFF_POS;  dc = gff_pkg::OFF_POS;  end
            default: begin dr = gff_pkg::OFF_ZERO; dc = gff_pkg::OFF_ZERO; end
        endcase
    end

    always_comb
    begin
        case (dr)
            gff_pkg::OFF_NEG:
            begin
                nr   = cur_r_reg - RW'(1);
                ok_r = (cur_r_reg != '0);
            end
            gff_pkg::OFF_POS:
            begin
                nr   = cur_r_reg + RW'(1);
                ok_r = (32'(cur_r_reg) != gff_pkg::ROWS - 1);
            end
            default:
            begin
                nr   = cur_r_reg;
                ok_r = 1'b1;
            end
        endcase
        case (dc)
            gff_pkg::OFF_NEG:
            begin
                nc   = cur_c_reg - CW'(1);
                ok_c = (cur_c_reg != '0);
            end
            gff_pkg::OFF_POS:
            begin
                nc   = cur_c_reg + CW'(1);
                ok_c = (32'(cur_c_reg) != gff_pkg::COLS - 1);
            end
            default:
            begin
                nc   = cur_c_reg;
                ok_c = 1'b1;
            end
        endcase
    end

    assign nbr_addr  = gff_pkg::cell_addr(nbr_r_reg, nbr_c_reg);
    assign cur_addr  = gff_pkg::cell_addr(cur_r_reg, cur_c_reg);
    assign mark      = cmd.nbr_check && walk_rdata && !vis_rdata;
    assign push_room = (32'(level_reg) < gff_pkg::NCELLS);
    assign level_dec = level_reg - gff_pkg::LEVEL_W'(1);

    // Memory port steering.
    always_comb
    begin
        walk_we    = (cmd.clr_step && cmd.clr_walk) || (cmd.in_write && in_inside);
        walk_waddr = cmd.in_write ? in_addr : clr_cnt_reg;
        walk_wdata = cmd.in_write ? gff_pkg::is_walk(in_char) : 1'b0;
        walk_raddr = cmd.nbr_issue ? gff_pkg::cell_addr(nr, nc) : in_addr;

        vis_we    = cmd.clr_step || cmd.seed || mark;
        vis_waddr = cmd.clr_step ? clr_cnt_reg : (cmd.seed ? cur_addr : nbr_addr);
        vis_wdata = !cmd.clr_step;
        vis_raddr = walk_raddr;

        stk_we    = cmd.seed || (mark && push_room);
        stk_waddr = cmd.seed ? '0 : level_reg[AW-1:0];
        stk_wdata = cmd.seed ? {cur_r_reg, cur_c_reg} : {nbr_r_reg, nbr_c_reg};
        stk_raddr = level_dec[AW-1:0];
    end

    gff_ram #(.WIDTH(1), .DEPTH(gff_pkg::NCELLS)) u_walk_ram (
        .clk   (clk),
        .we    (walk_we),
        .waddr (walk_waddr),
        .wdata (walk_wdata),
        .raddr (walk_raddr),
        .rdata (walk_rdata)
    );

    gff_ram #(.WIDTH(1), .DEPTH(gff_pkg::NCELLS)) u_vis_ram (
        .clk   (clk),
        .we    (vis_we),
        .waddr (vis_waddr),
        .wdata (vis_wdata),
        .raddr (vis_raddr),
        .rdata (vis_rdata)
    );

    gff_ram #(.WIDTH(gff_pkg::CELL_W), .DEPTH(gff_pkg::NCELLS)) u_stack_ram (
        .clk   (clk),
        .we    (stk_we),
        .waddr (stk_waddr),
        .wdata (stk_wdata),
        .raddr (stk_raddr),
        .rdata (stk_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_cnt_reg <= '0;
            level_reg   <= '0;
            m_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.clr_step)
            begin
                clr_cnt_reg <= stat.clr_done ? '0 : clr_cnt_reg + AW'(1);
            end
            if (cmd.seed)
            begin
                level_reg <= gff_pkg::LEVEL_W'(1);
            end
            else if (cmd.pop)
            begin
                level_reg <= level_dec;
            end
            else if (mark && push_room)
            begin
                level_reg <= level_reg + gff_pkg::LEVEL_W'(1);
            end
            if (cmd.out_load)
            begin
                m_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            inside_reg <= in_inside;
        end
        if (cmd.in_take)
        begin
            cur_r_reg <= in_row;
            cur_c_reg <= in_col;
        end
        else if (cmd.load_cur)
        begin
            cur_r_reg <= stk_rdata[gff_pkg::CELL_W-1:CW];
            cur_c_reg <= stk_rdata[CW-1:0];
        end
        if (cmd.chk_start)
        begin
            start_ok_reg <= inside_reg && walk_rdata;
        end
        if (cmd.load_cur)
        begin
            dir_reg <= '0;
        end
        else if (cmd.dir_inc)
        begin
            dir_reg <= dir_reg + gff_pkg::DIR_W'(1);
        end
        if (cmd.nbr_issue)
        begin
            nbr_r_reg <= nr;
            nbr_c_reg <= nc;
        end
        if (cmd.seed)
        begin
            count_reg <= gff_pkg::COUNT_W'(1);
        end
        else if (mark && (count_reg != gff_pkg::COUNT_MAX))
        begin
            count_reg <= count_reg + gff_pkg::COUNT_W'(1);
        end
        if (cmd.res_zero)
        begin
            res_sw_reg  <= 1'b0;
            res_cnt_reg <= '0;
            res_vm_reg  <= 1'b0;
        end
        else if (cmd.res_query)
        begin
            res_sw_reg  <= 1'b0;
            res_cnt_reg <= '0;
            res_vm_reg  <= inside_reg && vis_rdata;
        end
        else if (cmd.res_flood)
        begin
            res_sw_reg  <= 1'b1;
            res_cnt_reg <= count_reg;
            res_vm_reg  <= 1'b0;
        end
        if (cmd.out_load)
        begin
            m_sw_reg  <= res_sw_reg;
            m_cnt_reg <= res_cnt_reg;
            m_vm_reg  <= res_vm_reg;
        end
    end

    always_comb
    begin
        stat.clr_done   = (clr_cnt_reg == AW'(gff_pkg::NCELLS - 1));
        stat.level_zero = (level_reg == '0);
        stat.nbr_ok     = ok_r && ok_c;
        stat.dir_last   = (dir_reg == gff_pkg::DIR_LAST);
        stat.out_free   = !m_valid_reg || m_tready;
        stat.start_ok   = start_ok_reg;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = gff_pkg::M_DATA_W'({m_vm_reg, m_cnt_reg, m_sw_reg});

endmodule
`default_nettype wire
